### rtl/vgpl_pkg.sv
// Shared types, codes and helper functions of the voxel grid point labeler.
package vgpl_pkg;

   localparam int COORD_W = 32;
   localparam int LABEL_W = 10;
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int STATUS_W = 2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } cell_type;

   typedef struct packed {
      logic     first;
      cell_type vox;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_WRITE,
      ST_P1_RD,
      ST_P1_LD,
      ST_P1_SCAN,
      ST_P1_WR,
      ST_P2_RD,
      ST_P2_LD,
      ST_P2_SCAN,
      ST_P2_WR,
      ST_LOOKUP
   } state_type;

   // true when cell a comes before cell b in (z, y, x) order
   function automatic logic cell_less(input cell_type a, input cell_type b);
      logic res;
      if (a.z != b.z) begin
         res = a.z < b.z;
      end else if (a.y != b.y) begin
         res = a.y < b.y;
      end else begin
         res = a.x < b.x;
      end
      return res;
   endfunction

endpackage

### rtl/vgpl_if.sv
// Channel interfaces: point request, label response and register write.
interface vgpl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [vgpl_pkg::COORD_W-1:0]  coord_x;
   logic signed [vgpl_pkg::COORD_W-1:0]  coord_y;
   logic signed [vgpl_pkg::COORD_W-1:0]  coord_z;
   logic                                 final_point;
   logic [vgpl_pkg::INDEX_W-1:0]         point_index;
   modport source(output valid, kind, coord_x, coord_y, coord_z, final_point, point_index,
                  input ready);
   modport sink(input valid, kind, coord_x, coord_y, coord_z, final_point, point_index,
                output ready);
endinterface

interface vgpl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vgpl_pkg::LABEL_W-1:0]  voxel_label;
   logic [vgpl_pkg::COUNT_W-1:0]  voxel_count;
   logic [vgpl_pkg::STATUS_W-1:0] status;
   modport source(output valid, voxel_label, voxel_count, status, input ready);
   modport sink(input valid, voxel_label, voxel_count, status, output ready);
endinterface

interface vgpl_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

### rtl/vgpl_ram.sv
// Generic single-port RAM with registered read.
module vgpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/vgpl_divider.sv
// Bit-serial floor division of a signed coordinate by the unsigned voxel size.
module vgpl_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [vgpl_pkg::COORD_W-1:0] dividend,
   input  logic [vgpl_pkg::COORD_W-1:0]        divisor,
   output logic                                done,
   output logic signed [vgpl_pkg::COORD_W-1:0] quotient
);
   localparam int W = vgpl_pkg::COORD_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          fits;

   assign trial = {r_ff, q_ff[W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend[W-1] ? W'(-dividend) : W'(dividend);
         r_in    = '0;
         d_in    = divisor;
         neg_in  = dividend[W-1];
      end else if (busy_ff) begin
         q_in   = {q_ff[W-2:0], fits};
         r_in   = fits ? diff[W-1:0] : trial[W-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   always_comb begin
      if (!neg_ff) begin
         quotient = q_ff;
      end else if (r_ff != '0) begin
         quotient = ~q_ff;
      end else begin
         quotient = -q_ff;
      end
   end
endmodule

### rtl/voxel_grid_point_labeler_top.sv
// Top level of the voxel grid point labeler.
//
// req_bus carries load and read transactions, rsp_bus one response per read,
// csr_bus writes voxel_size (always ready, write only while idle).
// A load runs three serial 32-step floor divisions, one per coordinate,
// through a single shared divider, then one RAM write.
// A load with final_point set then runs the ranking sequencer over the
// point RAM: a duplicate-detect pass, scanning the entries before each
// point, and a rank pass, scanning all N stored points for each point.
// A read response becomes valid through the label RAM read, then the
// response register once that register is free.
// req_bus.ready is high only while the sequencer is idle, so items are
// taken one at a time.
// A stalled response holds in its register; further loads are still taken,
// while a read waits for the slot to free up.
// Reset clears the cloud counters and flags, sets voxel_size to 1.0 and
// leaves the RAM contents undefined; no clearing pass is needed.
module voxel_grid_point_labeler_top #(
   parameter int MAX_POINTS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   vgpl_req_if.sink     req_bus,
   vgpl_rsp_if.source   rsp_bus,
   vgpl_csr_if.sink     csr_bus
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int IW = (CW > vgpl_pkg::INDEX_W) ? CW : vgpl_pkg::INDEX_W;
   localparam int XW = (CW > vgpl_pkg::COUNT_W) ? CW : vgpl_pkg::COUNT_W;
   localparam int EW = $bits(vgpl_pkg::entry_type);
   localparam int LW = vgpl_pkg::LABEL_W;

   vgpl_pkg::state_type state_ff, state_in;

   logic [31:0]               vsize_ff, vsize_in;
   logic [CW-1:0]             loaded_ff, loaded_in;
   logic [CW-1:0]             kcnt_ff, kcnt_in;
   logic                      dropped_ff, dropped_in;
   logic                      lready_ff, lready_in;
   logic                      final_ff, final_in;
   logic                      idx_ok_ff, idx_ok_in;
   logic [1:0]                axis_ff, axis_in;
   logic                      div_start_ff, div_start_in;
   logic signed [31:0]        rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   vgpl_pkg::cell_type        cell_ff, cell_in;
   vgpl_pkg::cell_type        cur_ff, cur_in;
   logic [CW-1:0]             j_ff, j_in;
   logic [CW-1:0]             k_ff, k_in;
   logic                      sv_ff, sv_in;
   logic                      hit_ff, hit_in;
   logic [CW-1:0]             acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]             rsp_label_ff, rsp_label_in;
   logic [vgpl_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [vgpl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                      req_take;
   logic                      slot_free;
   logic [CW-1:0]             j_nx;
   logic signed [31:0]        div_operand;
   logic [31:0]               div_divisor;
   logic                      div_done;
   logic signed [31:0]        div_quot;
   logic                      pr_we, pr_re;
   logic [AW-1:0]             pr_addr;
   vgpl_pkg::entry_type       pr_wdata, pr_rdata;
   logic                      lb_we, lb_re;
   logic [AW-1:0]             lb_addr;
   logic [LW-1:0]             lb_wdata, lb_rdata;
   logic [XW-1:0]             kcnt_ext;

   assign req_bus.ready = (state_ff == vgpl_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take   = req_bus.valid && req_bus.ready;
   assign slot_free  = !rsp_valid_ff || rsp_bus.ready;
   assign j_nx       = j_ff + CW'(1);
   assign kcnt_ext   = XW'(kcnt_ff);
   assign div_divisor = (vsize_ff == '0) ? 32'd1 : vsize_ff;

   always_comb begin
      unique case (axis_ff)
         2'd0:    div_operand = rx_ff;
         2'd1:    div_operand = ry_ff;
         default: div_operand = rz_ff;
      endcase
   end

   vgpl_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_operand),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   vgpl_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (pr_we),
      .rd_en   (pr_re),
      .addr    (pr_addr),
      .wr_data (pr_wdata),
      .rd_data (pr_rdata)
   );

   vgpl_ram #(.WIDTH(LW), .DEPTH(MAX_POINTS)) u_label_ram (
      .clock   (clock),
      .wr_en   (lb_we),
      .rd_en   (lb_re),
      .addr    (lb_addr),
      .wr_data (lb_wdata),
      .rd_data (lb_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vgpl_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_bus.kind == vgpl_pkg::KIND_READ) begin
                  state_in = vgpl_pkg::ST_LOOKUP;
               end else if (lready_ff || loaded_ff < CW'(MAX_POINTS)) begin
                  state_in = vgpl_pkg::ST_DIV;
               end else if (req_bus.final_point) begin
                  state_in = vgpl_pkg::ST_P1_RD;
               end
            end
         end
         vgpl_pkg::ST_DIV: begin
            if (div_done && axis_ff == 2'd2) begin
               state_in = vgpl_pkg::ST_WRITE;
            end
         end
         vgpl_pkg::ST_WRITE: begin
            state_in = final_ff ? vgpl_pkg::ST_P1_RD : vgpl_pkg::ST_IDLE;
         end
         vgpl_pkg::ST_P1_RD:   state_in = vgpl_pkg::ST_P1_LD;
         vgpl_pkg::ST_P1_LD:   state_in = vgpl_pkg::ST_P1_SCAN;
         vgpl_pkg::ST_P1_SCAN: begin
            if (k_ff == j_ff && !sv_ff) begin
               state_in = vgpl_pkg::ST_P1_WR;
            end
         end
         vgpl_pkg::ST_P1_WR: begin
            state_in = (j_nx == loaded_ff) ? vgpl_pkg::ST_P2_RD : vgpl_pkg::ST_P1_RD;
         end
         vgpl_pkg::ST_P2_RD:   state_in = vgpl_pkg::ST_P2_LD;
         vgpl_pkg::ST_P2_LD:   state_in = vgpl_pkg::ST_P2_SCAN;
         vgpl_pkg::ST_P2_SCAN: begin
            if (k_ff == loaded_ff && !sv_ff) begin
               state_in = vgpl_pkg::ST_P2_WR;
            end
         end
         vgpl_pkg::ST_P2_WR: begin
            state_in = (j_nx == loaded_ff) ? vgpl_pkg::ST_IDLE : vgpl_pkg::ST_P2_RD;
         end
         vgpl_pkg::ST_LOOKUP: begin
            if (slot_free) begin
               state_in = vgpl_pkg::ST_IDLE;
            end
         end
         default: state_in = vgpl_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      vsize_in      = vsize_ff;
      loaded_in     = loaded_ff;
      kcnt_in       = kcnt_ff;
      dropped_in    = dropped_ff;
      lready_in     = lready_ff;
      final_in      = final_ff;
      idx_ok_in     = idx_ok_ff;
      axis_in       = axis_ff;
      div_start_in  = 1'b0;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rz_in         = rz_ff;
      cell_in       = cell_ff;
      cur_in        = cur_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      sv_in         = 1'b0;
      hit_in        = hit_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_label_in  = rsp_label_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      pr_we    = 1'b0;
      pr_re    = 1'b0;
      pr_addr  = j_ff[AW-1:0];
      pr_wdata = '{first: ~hit_ff, vox: cur_ff};
      lb_we    = 1'b0;
      lb_re    = 1'b0;
      lb_addr  = j_ff[AW-1:0];
      lb_wdata = LW'(acc_ff);

      if (csr_bus.valid) begin
         vsize_in = csr_bus.data;
      end

      unique case (state_ff)
         vgpl_pkg::ST_IDLE: begin
            if (req_take) begin
               rx_in    = req_bus.coord_x;
               ry_in    = req_bus.coord_y;
               rz_in    = req_bus.coord_z;
               final_in = req_bus.final_point;
               if (req_bus.kind == vgpl_pkg::KIND_READ) begin
                  idx_ok_in = lready_ff &&
                              (IW'(req_bus.point_index) < IW'(loaded_ff));
                  lb_re     = 1'b1;
                  lb_addr   = AW'(req_bus.point_index);
               end else begin
                  if (lready_ff) begin
                     loaded_in  = '0;
                     kcnt_in    = '0;
                     dropped_in = 1'b0;
                     lready_in  = 1'b0;
                  end
                  if (lready_ff || loaded_ff < CW'(MAX_POINTS)) begin
                     axis_in      = 2'd0;
                     div_start_in = 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                     j_in       = '0;
                     kcnt_in    = '0;
                  end
               end
            end
         end
         vgpl_pkg::ST_DIV: begin
            if (div_done) begin
               unique case (axis_ff)
                  2'd0:    cell_in.x = div_quot;
                  2'd1:    cell_in.y = div_quot;
                  default: cell_in.z = div_quot;
               endcase
               if (axis_ff != 2'd2) begin
                  axis_in      = axis_ff + 2'd1;
                  div_start_in = 1'b1;
               end
            end
         end
         vgpl_pkg::ST_WRITE: begin
            pr_we     = 1'b1;
            pr_addr   = loaded_ff[AW-1:0];
            pr_wdata  = '{first: 1'b0, vox: cell_ff};
            loaded_in = loaded_ff + CW'(1);
            j_in      = '0;
            kcnt_in   = '0;
         end
         vgpl_pkg::ST_P1_RD, vgpl_pkg::ST_P2_RD: begin
            pr_re = 1'b1;
         end
         vgpl_pkg::ST_P1_LD, vgpl_pkg::ST_P2_LD: begin
            cur_in = pr_rdata.vox;
            k_in   = '0;
            hit_in = 1'b0;
            acc_in = '0;
         end
         vgpl_pkg::ST_P1_SCAN: begin
            if (sv_ff && pr_rdata.vox == cur_ff) begin
               hit_in = 1'b1;
            end
            if (k_ff < j_ff) begin
               pr_re   = 1'b1;
               pr_addr = k_ff[AW-1:0];
               k_in    = k_ff + CW'(1);
               sv_in   = 1'b1;
            end
         end
         vgpl_pkg::ST_P1_WR: begin
            pr_we = 1'b1;
            if (!hit_ff) begin
               kcnt_in = kcnt_ff + CW'(1);
            end
            j_in = (j_nx == loaded_ff) ? '0 : j_nx;
         end
         vgpl_pkg::ST_P2_SCAN: begin
            if (sv_ff && pr_rdata.first && vgpl_pkg::cell_less(pr_rdata.vox, cur_ff)) begin
               acc_in = acc_ff + CW'(1);
            end
            if (k_ff < loaded_ff) begin
               pr_re   = 1'b1;
               pr_addr = k_ff[AW-1:0];
               k_in    = k_ff + CW'(1);
               sv_in   = 1'b1;
            end
         end
         vgpl_pkg::ST_P2_WR: begin
            lb_we = 1'b1;
            j_in  = j_nx;
            if (j_nx == loaded_ff) begin
               lready_in = 1'b1;
            end
         end
         vgpl_pkg::ST_LOOKUP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (!lready_ff) begin
                  rsp_label_in  = '0;
                  rsp_count_in  = '0;
                  rsp_status_in = vgpl_pkg::STATUS_BAD_IDX;
               end else if (!idx_ok_ff) begin
                  rsp_label_in  = '0;
                  rsp_count_in  = kcnt_ext[vgpl_pkg::COUNT_W-1:0];
                  rsp_status_in = vgpl_pkg::STATUS_BAD_IDX;
               end else begin
                  rsp_label_in  = lb_rdata;
                  rsp_count_in  = kcnt_ext[vgpl_pkg::COUNT_W-1:0];
                  rsp_status_in = dropped_ff ? vgpl_pkg::STATUS_DROPPED
                                             : vgpl_pkg::STATUS_OK;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vgpl_pkg::ST_IDLE;
         vsize_ff     <= 32'd65536;
         loaded_ff    <= '0;
         kcnt_ff      <= '0;
         dropped_ff   <= 1'b0;
         lready_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vsize_ff     <= vsize_in;
         loaded_ff    <= loaded_in;
         kcnt_ff      <= kcnt_in;
         dropped_ff   <= dropped_in;
         lready_ff    <= lready_in;
         div_start_ff <= div_start_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      final_ff      <= final_in;
      idx_ok_ff     <= idx_ok_in;
      axis_ff       <= axis_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      rz_ff         <= rz_in;
      cell_ff       <= cell_in;
      cur_ff        <= cur_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      hit_ff        <= hit_in;
      acc_ff        <= acc_in;
      rsp_label_ff  <= rsp_label_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.voxel_label = rsp_label_ff;
   assign rsp_bus.voxel_count = rsp_count_ff;
   assign rsp_bus.status      = rsp_status_ff;
endmodule

### rtl/vgpl_checker.sv
// Port-level assertions for the voxel grid point labeler, bound to the top level.
module vgpl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [vgpl_pkg::LABEL_W-1:0]  rsp_label,
   input logic [vgpl_pkg::COUNT_W-1:0]  rsp_count,
   input logic [vgpl_pkg::STATUS_W-1:0] rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_label) &&
      $stable(rsp_count) && $stable(rsp_status))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_label_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != vgpl_pkg::STATUS_BAD_IDX |-> {1'b0, rsp_label} < rsp_count)
      else $error("label not below voxel count");

   a_bad_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vgpl_pkg::STATUS_BAD_IDX |-> rsp_label == '0)
      else $error("nonzero label on bad index");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind voxel_grid_point_labeler_top vgpl_checker u_vgpl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_label  (rsp_bus.voxel_label),
   .rsp_count  (rsp_bus.voxel_count),
   .rsp_status (rsp_bus.status)
);
